[src/cfp_pkg.sv]
// shared types, constants and defaults for the converter fault protection block
package cfp_pkg;

    localparam int N_CH       = 4;
    localparam int SAMPLE_W   = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int WINDOW_DEF = 128;

    // channel order inside a sample vector
    localparam int CH_IN_CURRENT  = 0;
    localparam int CH_OUT_CURRENT = 1;
    localparam int CH_IN_VOLTAGE  = 2;
    localparam int CH_OUT_VOLTAGE = 3;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_UV_LEVEL    = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_OC_LEVEL    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SHORT_RATIO = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEB_LIMIT   = 2'd3;

    // configuration reset values
    localparam logic signed [CFG_W-1:0] UV_LEVEL_RST    = 16'sd23552;
    localparam logic signed [CFG_W-1:0] OC_LEVEL_RST    = 16'sd2560;
    localparam logic        [CFG_W-1:0] SHORT_RATIO_RST = 16'd6554;
    localparam logic        [CFG_W-1:0] DEB_LIMIT_RST   = 16'd500;

    localparam logic [CFG_W-1:0] DEB_CNT_MAX = 16'hFFFF;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef t_sample [N_CH-1:0] t_sample_vec;

    typedef enum logic [1:0] {
        FAULT_NORMAL      = 2'd0,
        FAULT_UNDERVOLT   = 2'd1,
        FAULT_OVERCURRENT = 2'd2,
        FAULT_SHORT       = 2'd3
    } t_fault;

endpackage

[src/converter_fault_protection.sv]
// top level: converter fault protection with windowed averages and debounced faults
//
// usage
//   s_axis carries one item per tick: four signed q6.10 samples in tdata and the
//   fault clear request in tuser. m_axis returns exactly one item per input item:
//   fault code, drive enable, window-complete flag and the four held averages.
//   the config port writes one register per cycle with i_cfg_we high; write it
//   only while the block is idle.
// timing
//   an item is registered on accept, then processed and lands in the result
//   register, which drives m_axis_tvalid. one item per cycle sustained while
//   m_axis_tready stays high; the single pass from input register to result
//   register (accumulate, shift, compare, 16x16 short-test multiply, debounce)
//   sets the clock.
// reset
//   synchronous active-low reset clears sums, count, averages, debounce counters
//   and fault state to normal and loads the default levels.
// backpressure
//   when m_axis_tready is low the result holds; one more item can wait in the
//   input register before s_axis_tready drops.
module converter_fault_protection #(
    parameter int WINDOW = cfp_pkg::WINDOW_DEF   // power of two
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // tdata: in_current_sample, out_current_sample, in_voltage_sample, out_voltage_sample
    input  logic [63:0]                    s_axis_tdata,
    // tuser: fault_clear
    input  logic                           s_axis_tuser,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: fault_code[1:0], drive_enable, averages_updated, avg_in_current,
    //        avg_out_current, avg_in_voltage, avg_out_voltage, 4 zero pad bits
    output logic [71:0]                    m_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic                           i_cfg_we,
    input  logic [cfp_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [cfp_pkg::CFG_W-1:0]      i_cfg_wdata
);
    import cfp_pkg::*;

    // configuration registers
    logic signed [CFG_W-1:0] r_uv_level;
    logic signed [CFG_W-1:0] r_oc_level;
    logic [CFG_W-1:0]        r_short_ratio;
    logic [CFG_W-1:0]        r_deb_limit;

    // input register
    logic        r_in_valid;
    t_sample_vec r_in_sample;
    logic        r_in_clear;

    // result register
    logic        r_out_valid;
    t_fault      r_out_code;
    logic        r_out_drive;
    logic        r_out_updated;
    t_sample_vec r_out_avg;

    // fault state
    t_fault r_fault;
    t_fault n_fault;

    logic        w_advance;
    logic        w_step;
    t_sample_vec w_avg;
    logic        w_updated;

    logic        w_uv_cond, w_oc_cond, w_sc_cond;
    logic        w_uv_fire, w_oc_fire, w_sc_fire;
    t_fault      w_fault_uv, w_fault_oc;

    t_sample     w_v, w_i;
    logic [15:0] w_v_mag, w_i_mag;
    logic [31:0] w_lhs, w_rhs;
    logic        w_is_short;

    // pipeline flow: the work stage fires when the result register can take it
    assign w_advance     = !r_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && w_advance;
    assign s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_step) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_sample <= t_sample_vec'(s_axis_tdata);
            r_in_clear  <= s_axis_tuser;
        end
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_uv_level    <= UV_LEVEL_RST;
            r_oc_level    <= OC_LEVEL_RST;
            r_short_ratio <= SHORT_RATIO_RST;
            r_deb_limit   <= DEB_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_UV_LEVEL:    r_uv_level    <= i_cfg_wdata;
                CFG_OC_LEVEL:    r_oc_level    <= i_cfg_wdata;
                CFG_SHORT_RATIO: r_short_ratio <= i_cfg_wdata;
                CFG_DEB_LIMIT:   r_deb_limit   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // averages after this item, including a window that completes now
    cfp_window_avg #(
        .WINDOW (WINDOW)
    ) u_avg (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (w_step),
        .i_sample  (r_in_sample),
        .o_avg     (w_avg),
        .o_updated (w_updated)
    );

    // undervoltage and overcurrent tests on the held averages
    assign w_uv_cond = $signed(w_avg[CH_IN_VOLTAGE]) < r_uv_level;
    assign w_oc_cond = $signed(w_avg[CH_OUT_CURRENT]) > r_oc_level;

    // short test: same sign, both nonzero, |v| * 2^16 < ratio * |i|
    assign w_v       = w_avg[CH_OUT_VOLTAGE];
    assign w_i       = w_avg[CH_OUT_CURRENT];
    assign w_v_mag   = w_v[15] ? 16'(~w_v + 16'd1) : 16'(w_v);
    assign w_i_mag   = w_i[15] ? 16'(~w_i + 16'd1) : 16'(w_i);
    assign w_lhs     = {w_v_mag, 16'h0000};
    assign w_rhs     = r_short_ratio * w_i_mag;
    assign w_is_short = (w_v != '0) && (w_i != '0) && (w_v[15] == w_i[15])
                        && (w_lhs < w_rhs);

    cfp_debounce u_deb_uv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_cond  (w_uv_cond),
        .i_limit (r_deb_limit),
        .o_fire  (w_uv_fire)
    );

    cfp_debounce u_deb_oc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_cond  (w_oc_cond),
        .i_limit (r_deb_limit),
        .o_fire  (w_oc_fire)
    );

    // later checks override earlier ones; short counts only while still normal
    assign w_fault_uv = w_uv_fire ? FAULT_UNDERVOLT : r_fault;
    assign w_fault_oc = w_oc_fire ? FAULT_OVERCURRENT : w_fault_uv;
    assign w_sc_cond  = (w_fault_oc == FAULT_NORMAL) && w_is_short;

    cfp_debounce u_deb_sc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_cond  (w_sc_cond),
        .i_limit (r_deb_limit),
        .o_fire  (w_sc_fire)
    );

    always_comb begin
        n_fault = w_sc_fire ? FAULT_SHORT : w_fault_oc;
        if (r_in_clear) begin
            n_fault = FAULT_NORMAL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fault <= FAULT_NORMAL;
        end else if (w_step) begin
            r_fault <= n_fault;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_code    <= n_fault;
            r_out_drive   <= (n_fault == FAULT_NORMAL);
            r_out_updated <= w_updated;
            r_out_avg     <= w_avg;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out_avg, r_out_updated, r_out_drive, r_out_code};

`ifndef SYNTH
    // the shown result always mirrors the current fault state
    a_out_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_code == r_fault))
        else $error("result fault code differs from fault state");

    // drive enable follows the fault code
    a_drive_enable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_drive == (r_out_code == FAULT_NORMAL)))
        else $error("drive enable inconsistent with fault code");

    // a processed clear request always yields a normal result
    a_clear_normal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && r_in_clear) |=> (r_out_code == FAULT_NORMAL))
        else $error("clear request did not return to normal");

    // input stalls only when an item is already held
    a_ready_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_in_valid)
        else $error("input stalled with empty input register");
`endif

endmodule

[src/cfp_window_avg.sv]
// windowed accumulators and held averages for the four converter channels
module cfp_window_avg #(
    parameter int WINDOW = cfp_pkg::WINDOW_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  cfp_pkg::t_sample_vec i_sample,
    output cfp_pkg::t_sample_vec o_avg,
    output logic                o_updated
);
    import cfp_pkg::*;

    localparam int WIN_BITS = $clog2(WINDOW);
    localparam int SUM_W    = SAMPLE_W + WIN_BITS;
    localparam logic [WIN_BITS-1:0] LAST_CNT = WIN_BITS'(WINDOW - 1);

    logic signed [SUM_W-1:0] r_sum [N_CH];
    logic signed [SUM_W-1:0] n_sum [N_CH];
    logic [WIN_BITS-1:0]     r_count;
    t_sample_vec             r_avg;
    logic                    w_last;

    assign w_last    = (r_count == LAST_CNT);
    assign o_updated = i_step && w_last;

    always_comb begin
        for (int k = 0; k < N_CH; k++) begin
            n_sum[k] = r_sum[k] + {{WIN_BITS{i_sample[k][SAMPLE_W-1]}}, i_sample[k]};
            // arithmetic shift of the sum gives the floor average
            o_avg[k] = o_updated ? t_sample'(n_sum[k][SUM_W-1:WIN_BITS]) : r_avg[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_avg   <= '0;
            for (int k = 0; k < N_CH; k++) begin
                r_sum[k] <= '0;
            end
        end else if (i_step) begin
            if (w_last) begin
                r_count <= '0;
                r_avg   <= o_avg;
                for (int k = 0; k < N_CH; k++) begin
                    r_sum[k] <= '0;
                end
            end else begin
                r_count <= r_count + 1'b1;
                for (int k = 0; k < N_CH; k++) begin
                    r_sum[k] <= n_sum[k];
                end
            end
        end
    end

endmodule

[src/cfp_debounce.sv]
// saturating debounce counter that fires once a condition outlasts the limit
module cfp_debounce (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_step,
    input  logic                      i_cond,
    input  logic [cfp_pkg::CFG_W-1:0] i_limit,
    output logic                      o_fire
);
    import cfp_pkg::*;

    logic [CFG_W-1:0] r_count;
    logic [CFG_W-1:0] n_count;
    logic [CFG_W-1:0] w_inc;

    assign w_inc = (r_count == DEB_CNT_MAX) ? r_count : r_count + 1'b1;

    always_comb begin
        n_count = r_count;
        o_fire  = 1'b0;
        if (i_step) begin
            if (!i_cond) begin
                n_count = '0;
            end else if (w_inc > i_limit) begin
                n_count = '0;
                o_fire  = 1'b1;
            end else begin
                n_count = w_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule

[sim/converter_fault_protection_tb.sv]
// self-checking testbench for converter_fault_protection: streamed samples against a fault predictor
module converter_fault_protection_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cfp_pkg::*;

    localparam int CLK_HALF        = 5;
    localparam int RESET_CYCLES    = 10;
    localparam int N_PHASES        = 6;
    localparam int ITEMS_PER_PHASE = 125;
    // the limit leaves a wide margin over the slowest correct run
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 10;
    localparam int MAX_PRINTED     = 100;
    localparam int AVG_SHIFT       = $clog2(WINDOW_DEF);
    localparam int S_MAX           = 32767;
    localparam int S_MIN           = -32768;
    localparam logic [CFG_W-1:0] DEB_LIMIT_TOP = 16'd65534;

    // debounce counter slots, in check order
    localparam int DEB_UV    = 0;
    localparam int DEB_OC    = 1;
    localparam int DEB_SHORT = 2;

    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} t_idle_mode;

    // what the samples of one window look like
    typedef enum int {MIX_RANDOM, MIX_HEALTHY, MIX_SHORT, MIX_EDGE} t_mix;

    // result item as it sits on m_axis_tdata, fault_code in the lowest bits
    typedef struct packed {
        logic [3:0] pad;
        t_sample    avg_out_voltage;
        t_sample    avg_in_voltage;
        t_sample    avg_out_current;
        t_sample    avg_in_current;
        logic       averages_updated;
        logic       drive_enable;
        t_fault     fault_code;
    } t_status;

    // predictor of the protection logic plus the queue of status items it expects
    class protection_checker;
        t_sample              uv_level;
        t_sample              oc_level;
        logic [CFG_W-1:0]     short_ratio;
        logic [CFG_W-1:0]     deb_limit;
        logic signed [22:0]   window_sum [N_CH];
        int unsigned          fill;
        t_sample              held_avg [N_CH];
        logic [CFG_W-1:0]     deb_count [3];
        t_fault               fault;
        t_status              expected_status [$];
        int                   errors;
        int                   n_checked;

        function new();
            uv_level    = UV_LEVEL_RST;
            oc_level    = OC_LEVEL_RST;
            short_ratio = SHORT_RATIO_RST;
            deb_limit   = DEB_LIMIT_RST;
            foreach (window_sum[ch]) begin
                window_sum[ch] = '0;
                held_avg[ch]   = '0;
            end
            foreach (deb_count[k]) deb_count[k] = '0;
            fill      = 0;
            fault     = FAULT_NORMAL;
            errors    = 0;
            n_checked = 0;
        endfunction

        function int pending();
            return expected_status.size();
        endfunction

        function void report(string msg);
            errors++;
            if (errors <= MAX_PRINTED) $display("mismatch: %s", msg);
        endfunction

        // a condition has to outlast the limit; counters saturate and restart on a latch
        function bit count_condition(int idx, bit cond);
            if (!cond) begin
                deb_count[idx] = '0;
                return 1'b0;
            end
            if (deb_count[idx] != DEB_CNT_MAX) deb_count[idx] = deb_count[idx] + 1'b1;
            if (deb_count[idx] > deb_limit) begin
                deb_count[idx] = '0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // 0 < v/i < ratio/65536 by cross-multiplying magnitudes
        function bit looks_shorted(t_sample v, t_sample i);
            logic [SAMPLE_W-1:0] mag_v;
            logic [SAMPLE_W-1:0] mag_i;
            logic [31:0]         lhs;
            logic [31:0]         rhs;
            if (v == 0 || i == 0 || v[SAMPLE_W-1] != i[SAMPLE_W-1]) return 1'b0;
            mag_v = v[SAMPLE_W-1] ? -v : v;
            mag_i = i[SAMPLE_W-1] ? -i : i;
            lhs   = {mag_v, 16'h0000};
            rhs   = 32'(short_ratio) * 32'(mag_i);
            return lhs < rhs;
        endfunction

        function void note_sample_set(logic [63:0] data, logic clear);
            t_status st;
            t_sample smp;
            bit      updated;
            updated = 1'b0;
            foreach (window_sum[ch]) begin
                smp = data[ch*SAMPLE_W +: SAMPLE_W];
                window_sum[ch] = window_sum[ch] + smp;
            end
            fill++;
            if (fill == WINDOW_DEF) begin
                // upper bits of the sum are the floor of sum / window
                foreach (window_sum[ch]) begin
                    held_avg[ch]   = window_sum[ch][AVG_SHIFT +: SAMPLE_W];
                    window_sum[ch] = '0;
                end
                fill    = 0;
                updated = 1'b1;
            end
            if (count_condition(DEB_UV, held_avg[CH_IN_VOLTAGE] < uv_level))
                fault = FAULT_UNDERVOLT;
            if (count_condition(DEB_OC, held_avg[CH_OUT_CURRENT] > oc_level))
                fault = FAULT_OVERCURRENT;
            if (count_condition(DEB_SHORT, fault == FAULT_NORMAL &&
                    looks_shorted(held_avg[CH_OUT_VOLTAGE], held_avg[CH_OUT_CURRENT])))
                fault = FAULT_SHORT;
            if (clear) fault = FAULT_NORMAL;

            st.pad              = '0;
            st.fault_code       = fault;
            st.drive_enable     = (fault == FAULT_NORMAL);
            st.averages_updated = updated;
            st.avg_in_current   = held_avg[CH_IN_CURRENT];
            st.avg_out_current  = held_avg[CH_OUT_CURRENT];
            st.avg_in_voltage   = held_avg[CH_IN_VOLTAGE];
            st.avg_out_voltage  = held_avg[CH_OUT_VOLTAGE];
            expected_status.push_back(st);
        endfunction

        function void compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report($sformatf("result %0d %s is %h, expected %h", n_checked, name, got, want));
        endfunction

        function void check_status(logic [71:0] data);
            t_status got;
            t_status want;
            got = t_status'(data);
            n_checked++;
            if (expected_status.size() == 0) begin
                report($sformatf("result %0d arrived with nothing expected", n_checked));
                return;
            end
            want = expected_status.pop_front();
            compare_field("fault_code", 16'(got.fault_code), 16'(want.fault_code));
            compare_field("drive_enable", 16'(got.drive_enable), 16'(want.drive_enable));
            compare_field("averages_updated", 16'(got.averages_updated),
                          16'(want.averages_updated));
            compare_field("avg_in_current", got.avg_in_current, want.avg_in_current);
            compare_field("avg_out_current", got.avg_out_current, want.avg_out_current);
            compare_field("avg_in_voltage", got.avg_in_voltage, want.avg_in_voltage);
            compare_field("avg_out_voltage", got.avg_out_voltage, want.avg_out_voltage);
            compare_field("pad", 16'(got.pad), 16'(want.pad));
        endfunction
    endclass

    // dut connections, all inputs known from time zero
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic [63:0]           s_axis_tdata  = '0;
    logic                  s_axis_tuser  = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [71:0]           m_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b1;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    logic [CFG_W-1:0]      i_cfg_wdata   = '0;

    // idling knobs, percentages of cycles
    int          sender_idle_pct = 0;
    int          recv_stall_pct  = 0;
    bit          quiet           = 1'b0;
    int unsigned cycles          = 0;

    // window shaping for the random part
    int          mean [N_CH];
    int          spread     = 0;
    int unsigned items_sent = 0;

    protection_checker prot_model;

    converter_fault_protection uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // receiver stalls, quiet stretches and the run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        // roughly one stretch in four runs with no idling at all
        if (cycles % 64 == 0) quiet <= ($urandom_range(3) == 0);
        m_axis_tready <= quiet || ($urandom_range(99) >= recv_stall_pct);
        if (cycles >= CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // result monitor: values read here are the ones sampled at this edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) prot_model.check_status(m_axis_tdata);
    end

    function automatic t_sample clamp16(int v);
        if (v > S_MAX) return t_sample'(S_MAX);
        if (v < S_MIN) return t_sample'(S_MIN);
        return t_sample'(v);
    endfunction

    // called at a clock edge; valid stays high between back-to-back items
    task automatic send_item(logic [63:0] data, logic clear);
        int gap;
        gap = 0;
        if (!quiet) begin
            while ($urandom_range(99) < sender_idle_pct) gap++;
        end
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= data;
        s_axis_tuser  <= clear;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        prot_model.note_sample_set(data, clear);
        items_sent++;
    endtask

    // drop valid and let every expected item come back before touching registers
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (prot_model.pending() != 0) @(posedge i_clk);
    endtask

    // back-to-back register writes, enable held high across them
    task automatic apply_settings(t_sample uv, t_sample oc, logic [CFG_W-1:0] ratio,
                                  logic [CFG_W-1:0] limit);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_UV_LEVEL;
        i_cfg_wdata <= uv;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_OC_LEVEL;
        i_cfg_wdata <= oc;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_SHORT_RATIO;
        i_cfg_wdata <= ratio;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_DEB_LIMIT;
        i_cfg_wdata <= limit;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        prot_model.uv_level    = uv;
        prot_model.oc_level    = oc;
        prot_model.short_ratio = ratio;
        prot_model.deb_limit   = limit;
    endtask

    // levels and idling per phase; phase 0 keeps the reset levels
    task automatic set_phase(int phase);
        case (phase)
            1: begin
                // widest short ratio, latch on the first tick of a condition
                apply_settings(t_sample'($urandom), t_sample'($urandom), 16'hFFFF, '0);
            end
            2: begin
                // levels at the ends of the range leave only the short check alive
                apply_settings(t_sample'(S_MIN), t_sample'(S_MAX), 16'($urandom),
                               16'($urandom_range(7)));
            end
            3: begin
                // opposite level extremes with the longest limit that can still latch: counters run, nothing latches
                apply_settings(t_sample'(S_MAX), t_sample'(S_MIN), '0, DEB_LIMIT_TOP);
            end
            4: begin
                apply_settings(t_sample'($urandom), t_sample'($urandom), 16'($urandom),
                               16'($urandom_range(15)));
            end
            5: begin
                apply_settings(t_sample'($urandom_range(0, 30000)),
                               t_sample'($urandom_range(0, 8000)), 16'($urandom),
                               16'($urandom_range(40)));
            end
            default: ;
        endcase
        case (t_idle_mode'(phase % 4))
            IDLE_NONE:     begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
            IDLE_SENDER:   begin sender_idle_pct = 74; recv_stall_pct = 0;  end
            IDLE_RECEIVER: begin sender_idle_pct = 0;  recv_stall_pct = 74; end
            IDLE_BOTH:     begin sender_idle_pct = 15; recv_stall_pct = 15; end
        endcase
    endtask

    // choose the means of the next window so that the averages land where the checks bite
    task automatic pick_mix();
        t_mix mix;
        int   spreads [4] = '{0, 15, 255, 4095};
        mix    = t_mix'($urandom_range(3));
        spread = spreads[$urandom_range(3)];
        foreach (mean[ch]) mean[ch] = int'(t_sample'($urandom));
        case (mix)
            MIX_HEALTHY: begin
                mean[CH_IN_VOLTAGE]  = int'(prot_model.uv_level) + int'($urandom_range(1, 3000));
                mean[CH_OUT_CURRENT] = int'(prot_model.oc_level) - int'($urandom_range(1, 3000));
                mean[CH_OUT_VOLTAGE] = int'($urandom_range(1000, S_MAX));
            end
            MIX_SHORT: begin
                // output voltage right around ratio/65536 times current, same sign
                spread = spreads[$urandom_range(2)];
                if ($urandom_range(7) == 0) mean[CH_OUT_CURRENT] = 0;
                mean[CH_OUT_VOLTAGE] = int'((longint'(mean[CH_OUT_CURRENT]) *
                                             longint'(prot_model.short_ratio)) >>> 16)
                                       + int'($urandom_range(6)) - 3;
            end
            MIX_EDGE: begin
                // averages within two steps either side of the levels
                spread = spreads[$urandom_range(1)];
                mean[CH_IN_VOLTAGE]  = int'(prot_model.uv_level) + int'($urandom_range(4)) - 2;
                mean[CH_OUT_CURRENT] = int'(prot_model.oc_level) + int'($urandom_range(4)) - 2;
            end
            default: ;
        endcase
    endtask

    task automatic send_random_item();
        logic [63:0] data;
        if (items_sent % WINDOW_DEF == 0) pick_mix();
        if ($urandom_range(15) == 0) begin
            // noise item that breaks the window's pattern
            data = {$urandom, $urandom};
        end else begin
            foreach (mean[ch])
                data[ch*SAMPLE_W +: SAMPLE_W] =
                    clamp16(mean[ch] + int'($urandom_range(2 * spread)) - spread);
        end
        send_item(data, $urandom_range(23) == 0);
    endtask

    // field extremes, bit patterns and clear requests straight after reset
    task automatic send_directed();
        send_item({4{16'h0000}}, 1'b0);
        send_item({4{16'h7FFF}}, 1'b0);
        send_item({4{16'h8000}}, 1'b0);
        send_item({4{16'hFFFF}}, 1'b1);
        send_item({4{16'h0001}}, 1'b0);
        send_item({4{16'h5555}}, 1'b0);
        send_item({4{16'hAAAA}}, 1'b1);
        send_item({16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, 1'b0);
        send_item({16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, 1'b1);
        send_item({16'h0000, 16'h0001, 16'hFFFF, 16'h0000}, 1'b0);
        send_item({4{16'h0000}}, 1'b1);
    endtask

    initial begin
        prot_model = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < N_PHASES; phase++) begin
            // registers change only with nothing in flight
            if (phase != 0) wait_idle();
            set_phase(phase);
            if (phase == 0) begin
                send_directed();
                pick_mix();
            end
            repeat (ITEMS_PER_PHASE) send_random_item();
        end

        // every result back, then a drain wait for anything stray
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (prot_model.errors == 0 && prot_model.pending() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

[converter_fault_protection.f]
src/cfp_pkg.sv
src/cfp_window_avg.sv
src/cfp_debounce.sv
src/converter_fault_protection.sv
sim/converter_fault_protection_tb.sv
